[sv/terrain_vertex_mask_shader_unit_assert.svh]
// ----------------------------------------------------------------------------
// Terrain vertex mask shader assertion macros
// Shared concurrent check forms, sampled on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_VERTEX_MASK_SHADER_UNIT_ASSERT_SVH
`define TERRAIN_VERTEX_MASK_SHADER_UNIT_ASSERT_SVH

// check a property at every clock edge
`define TVMS_ASSERT_NOW(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("terrain vertex mask check failed");

// check that a condition implies a property in the same cycle
`define TVMS_ASSERT_IMP(lbl, pre, post) \
  `TVMS_ASSERT_NOW(lbl, (pre) |-> (post))

`endif

[sv/tvms_pkg.sv]
// ----------------------------------------------------------------------------
// Terrain vertex mask shader package
// Shared constants: register indexes, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tvms_pkg;

  localparam int HEIGHT_BITS_DEF    = 24;
  localparam int MASK_FRAC_BITS_DEF = 12;

  localparam logic [1:0] CFG_FIELD_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_FIELD_DEPTH    = 2'd1;
  localparam logic [1:0] CFG_GRID_SPACING   = 2'd2;
  localparam logic [1:0] CFG_EXPOSURE_DEPTH = 2'd3;

  localparam logic [16:0] FIELD_WIDTH_RST    = 17'd256;
  localparam logic [16:0] FIELD_DEPTH_RST    = 17'd256;
  localparam logic [15:0] GRID_SPACING_RST   = 16'd1600;
  localparam logic [15:0] EXPOSURE_DEPTH_RST = 16'd128;

  // quotient bits of the parallel dividers (slopes, exposure)
  localparam int DIV_QW = 24;
  // Q16 slope saturation at 2.0
  localparam logic [17:0] SLOPE_SAT = 18'h20000;
  localparam logic [35:0] T_ONE     = 36'h1_0000_0000;
  localparam logic [62:0] UP2_NUM   = 63'h4000_0000_0000_0000;
  localparam int UP2_QW = 31;

  localparam logic [15:0] UP_LO   = 16'd23593;
  localparam logic [15:0] UP_HI   = 16'd31130;
  localparam logic [12:0] UP_SPAN = 13'd7537;

  localparam logic [31:0] HASH_X  = 32'd73856093;
  localparam logic [31:0] HASH_Y  = 32'd19349663;
  localparam logic [9:0]  VAR_MOD = 10'd1000;
  // reciprocal of 1000, exact quotient for every 32-bit hash
  localparam logic [31:0] VAR_RECIP = 32'd274877907;
  localparam int          VAR_SHIFT = 38;

endpackage

`default_nettype wire

[sv/tvms_div_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, overflow flagged when the quotient needs more
// than QW bits. Side data and valid travel with each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tvms_div_pipe #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vin,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               vout,
  output logic [QW-1:0]      q,
  output logic [DW-1:0]      rem,
  output logic               ovf,
  output logic [SW-1:0]      side_out
);

  localparam int RW = DW + QW;
  localparam int CW = (NW > RW) ? NW : RW;

  logic [CW-1:0] num_c;
  logic [CW-1:0] den_c;

  logic [QW:0]   v_s;
  logic [RW-1:0] r_s [0:QW];
  logic [QW-1:0] q_s [0:QW];
  logic [DW-1:0] d_s [0:QW];
  logic [SW-1:0] s_s [0:QW];
  logic          o_s [0:QW];

  always_comb begin
    num_c = CW'(num);
    den_c = CW'(den) << QW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s <= '0;
    end else if (en) begin
      v_s <= {v_s[QW-1:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0] <= num_c[RW-1:0];
      q_s[0] <= '0;
      d_s[0] <= den;
      s_s[0] <= side;
      o_s[0] <= (num_c >= den_c);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [RW-1:0] sh;
    logic          ge;

    always_comb begin
      sh = RW'(d_s[k-1]) << B;
      ge = (r_s[k-1] >= sh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[k] <= ge ? (r_s[k-1] - sh) : r_s[k-1];
        q_s[k] <= q_s[k-1] | (QW'(ge) << B);
        d_s[k] <= d_s[k-1];
        s_s[k] <= s_s[k-1];
        o_s[k] <= o_s[k-1];
      end
    end
  end

  assign vout     = v_s[QW];
  assign q        = q_s[QW];
  assign rem      = r_s[QW][DW-1:0];
  assign ovf      = o_s[QW];
  assign side_out = s_s[QW];

endmodule

`default_nettype wire

[sv/tvms_isqrt_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a VW-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tvms_isqrt_pipe #(
  parameter int VW = 32,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            vin,
  input  wire logic [VW-1:0]   val,
  input  wire logic [SW-1:0]   side,
  output logic                 vout,
  output logic [VW/2-1:0]      root,
  output logic [SW-1:0]        side_out
);

  localparam int N = VW / 2;

  logic [N:0]    v_s;
  logic [VW-1:0] x_s [0:N];
  logic [VW-1:0] r_s [0:N];
  logic [SW-1:0] s_s [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s <= '0;
    end else if (en) begin
      v_s <= {v_s[N-1:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0] <= val;
      r_s[0] <= '0;
      s_s[0] <= side;
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_stage
    localparam int BP = VW - 2 * i;
    logic [VW-1:0] bt;
    logic [VW-1:0] sum;
    logic          ge;

    always_comb begin
      bt  = VW'(1) << BP;
      sum = r_s[i-1] + bt;
      ge  = (x_s[i-1] >= sum);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s[i] <= ge ? (x_s[i-1] - sum) : x_s[i-1];
        r_s[i] <= ge ? ((r_s[i-1] >> 1) + bt) : (r_s[i-1] >> 1);
        s_s[i] <= s_s[i-1];
      end
    end
  end

  assign vout     = v_s[N];
  assign root     = r_s[N][N-1:0];
  assign side_out = s_s[N];

endmodule

`default_nettype wire

[sv/terrain_vertex_mask_shader_unit.sv]
// ----------------------------------------------------------------------------
// Terrain vertex mask shader
// Flatness, exposure and variation masks for one heightfield vertex a beat.
//
//   channel  | handshake                  | payload
//   vertex   | vertex_valid/vertex_stall  | coordinates, six heights
//   mask     | mask_valid/mask_stall      | flatness, exposure, variation
//   config   | cfg_we                     | cfg_index, cfg_data
//
// One vertex a cycle unless mask_stall holds the pipeline; from accept to mask_valid
// a vertex passes the slope dividers, the 1/T divider and the square root.
// The whole pipeline advances together; a stalled mask beat holds every stage
// and raises vertex_stall in the same cycle.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "terrain_vertex_mask_shader_unit_assert.svh"

module terrain_vertex_mask_shader_unit
  import tvms_pkg::*;
#(
  parameter int HEIGHT_BITS    = HEIGHT_BITS_DEF,
  parameter int MASK_FRAC_BITS = MASK_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [16:0]                   cfg_data,
  input  wire logic                          vertex_valid,
  output logic                               vertex_stall,
  input  wire logic [15:0]                   vertex_x,
  input  wire logic [15:0]                   vertex_y,
  input  wire logic signed [HEIGHT_BITS-1:0] center_height,
  input  wire logic signed [HEIGHT_BITS-1:0] base_height,
  input  wire logic signed [HEIGHT_BITS-1:0] left_height,
  input  wire logic signed [HEIGHT_BITS-1:0] right_height,
  input  wire logic signed [HEIGHT_BITS-1:0] down_height,
  input  wire logic signed [HEIGHT_BITS-1:0] up_height,
  output logic                               mask_valid,
  input  wire logic                          mask_stall,
  output logic [MASK_FRAC_BITS:0]            flatness,
  output logic [MASK_FRAC_BITS:0]            exposure,
  output logic [9:0]                         variation
);

  localparam int HB = HEIGHT_BITS;
  localparam int F  = MASK_FRAC_BITS;
  localparam int SDW = F + 11;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam int FLAT_K = 13 + F;
  localparam logic [F:0] FLAT_M = (F+1)'((64'd1 << FLAT_K) / UP_SPAN);
  localparam int HR_N = DIV_QW - 1;

  logic adv;

  logic [16:0] field_width;
  logic [16:0] field_depth;
  logic [15:0] grid_spacing;
  logic [15:0] exposure_depth;

  assign adv          = !mask_valid || !mask_stall;
  assign vertex_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width    <= FIELD_WIDTH_RST;
      field_depth    <= FIELD_DEPTH_RST;
      grid_spacing   <= GRID_SPACING_RST;
      exposure_depth <= EXPOSURE_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIELD_WIDTH:    field_width    <= cfg_data;
        CFG_FIELD_DEPTH:    field_depth    <= cfg_data;
        CFG_GRID_SPACING:   grid_spacing   <= cfg_data[15:0];
        CFG_EXPOSURE_DEPTH: exposure_depth <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic              x_lo, x_hi, y_lo, y_hi;
  logic [1:0]        nx, ny;
  logic [HB-1:0]     ax, bx, ay, by;
  logic signed [HB:0] dx, dy, de;
  logic [HB:0]       mx, my, me;
  logic [15:0]       sp, dp;
  logic [16:0]       dnx, dny;
  logic [HB+16:0]    nmx, nmy;
  logic [HB+F:0]     nme;
  logic [31:0]       hsh;

  always_comb begin
    sp   = (grid_spacing == 16'd0) ? 16'd1 : grid_spacing;
    dp   = (exposure_depth == 16'd0) ? 16'd1 : exposure_depth;
    x_lo = (vertex_x != 16'd0);
    x_hi = (({1'b0, vertex_x} + 17'd1) < field_width);
    y_lo = (vertex_y != 16'd0);
    y_hi = (({1'b0, vertex_y} + 17'd1) < field_depth);
    nx   = {1'b0, x_lo} + {1'b0, x_hi};
    ny   = {1'b0, y_lo} + {1'b0, y_hi};
    ax   = x_hi ? right_height : center_height;
    bx   = x_lo ? left_height  : center_height;
    ay   = y_hi ? up_height    : center_height;
    by   = y_lo ? down_height  : center_height;
    dx   = {ax[HB-1], ax} - {bx[HB-1], bx};
    dy   = {ay[HB-1], ay} - {by[HB-1], by};
    de   = {center_height[HB-1], center_height} - {base_height[HB-1], base_height};
    mx   = dx[HB] ? (~dx + 1'b1) : dx;
    my   = dy[HB] ? (~dy + 1'b1) : dy;
    me   = de[HB] ? (~de + 1'b1) : de;
    case (nx)
      2'd0:    dnx = 17'd1;
      2'd1:    dnx = {1'b0, sp};
      default: dnx = {sp, 1'b0};
    endcase
    case (ny)
      2'd0:    dny = 17'd1;
      2'd1:    dny = {1'b0, sp};
      default: dny = {sp, 1'b0};
    endcase
    nmx  = (nx == 2'd0) ? '0 : {mx, 16'd0};
    nmy  = (ny == 2'd0) ? '0 : {my, 16'd0};
    nme  = {me, {F{1'b0}}};
    hsh  = ({16'd0, vertex_x} * HASH_X) ^ ({16'd0, vertex_y} * HASH_Y);
  end

  logic           p1_v;
  logic [HB+16:0] p1_nmx, p1_nmy;
  logic [16:0]    p1_dnx, p1_dny;
  logic [HB+F:0]  p1_nme;
  logic [15:0]    p1_dp;
  logic [31:0]    p1_hsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (adv) begin
      p1_v <= vertex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_nmx <= nmx;
      p1_nmy <= nmy;
      p1_dnx <= dnx;
      p1_dny <= dny;
      p1_nme <= nme;
      p1_dp  <= dp;
      p1_hsh <= hsh;
    end
  end

  // parallel dividers
  logic              dv_v;
  logic [DIV_QW-1:0] sx_q, sy_q, ex_q;
  logic              sx_o, sy_o, ex_o;
  logic [9:0]        hq_r;

  tvms_div_pipe #(.NW(HB+17), .DW(17), .QW(DIV_QW), .SW(1)) u_div_sx (
    .clk(clk), .rst(rst), .en(adv), .vin(p1_v), .num(p1_nmx), .den(p1_dnx),
    .side(1'b0), .vout(dv_v), .q(sx_q), .rem(), .ovf(sx_o), .side_out()
  );

  tvms_div_pipe #(.NW(HB+17), .DW(17), .QW(DIV_QW), .SW(1)) u_div_sy (
    .clk(clk), .rst(rst), .en(adv), .vin(p1_v), .num(p1_nmy), .den(p1_dny),
    .side(1'b0), .vout(), .q(sy_q), .rem(), .ovf(sy_o), .side_out()
  );

  tvms_div_pipe #(.NW(HB+F+1), .DW(16), .QW(DIV_QW), .SW(1)) u_div_ex (
    .clk(clk), .rst(rst), .en(adv), .vin(p1_v), .num(p1_nme), .den(p1_dp),
    .side(1'b0), .vout(), .q(ex_q), .rem(), .ovf(ex_o), .side_out()
  );

  // hash residue: reciprocal quotient, subtract, then delay to the dividers
  logic [63:0] hm_p;
  logic [31:0] hm_h, hr_h;
  logic [22:0] hr_q;
  logic [9:0]  h_r [0:HR_N-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      hm_p   <= 64'(p1_hsh) * 64'(VAR_RECIP);
      hm_h   <= p1_hsh;
      hr_q   <= hm_p[VAR_SHIFT+22:VAR_SHIFT];
      hr_h   <= hm_h;
      h_r[0] <= 10'(hr_h - 32'(hr_q) * 32'(VAR_MOD));
      for (int i = 1; i < HR_N; i++) begin
        h_r[i] <= h_r[i-1];
      end
    end
  end

  assign hq_r = h_r[HR_N-1];

  // saturate slopes and exposure
  logic        g_v;
  logic [17:0] g_x, g_y;
  logic [F:0]  g_e;
  logic [9:0]  g_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_x <= (sx_o || sx_q > DIV_QW'(SLOPE_SAT)) ? SLOPE_SAT : sx_q[17:0];
      g_y <= (sy_o || sy_q > DIV_QW'(SLOPE_SAT)) ? SLOPE_SAT : sy_q[17:0];
      g_e <= (ex_o || ex_q > DIV_QW'(ONE)) ? ONE : ex_q[F:0];
      g_r <= hq_r;
    end
  end

  // squares and T
  logic           sq_v, t_v;
  logic [35:0]    sq_x, sq_y, t_val;
  logic [SDW-1:0] sq_s, t_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
      t_v  <= 1'b0;
    end else if (adv) begin
      sq_v <= g_v;
      t_v  <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x  <= 36'(g_x) * 36'(g_x);
      sq_y  <= 36'(g_y) * 36'(g_y);
      sq_s  <= {g_e, g_r};
      t_val <= T_ONE + sq_x + sq_y;
      t_s   <= sq_s;
    end
  end

  // 2^62 / T, then square root
  logic              u_v;
  logic [UP2_QW-1:0] u_q;
  logic [SDW-1:0]    u_s;
  logic              r_v;
  logic [15:0]       r_up;
  logic [SDW-1:0]    r_s;

  tvms_div_pipe #(.NW(63), .DW(36), .QW(UP2_QW), .SW(SDW)) u_div_up2 (
    .clk(clk), .rst(rst), .en(adv), .vin(t_v), .num(UP2_NUM), .den(t_val),
    .side(t_s), .vout(u_v), .q(u_q), .rem(), .ovf(), .side_out(u_s)
  );

  tvms_isqrt_pipe #(.VW(32), .SW(SDW)) u_isqrt (
    .clk(clk), .rst(rst), .en(adv), .vin(u_v), .val({1'b0, u_q}),
    .side(u_s), .vout(r_v), .root(r_up), .side_out(r_s)
  );

  // smoothstep
  logic [5:0]          c_v;
  logic [SDW-1:0]      c_s [0:5];
  logic [5:0]          c_lo, c_hi;
  logic [12:0]         c1_d;
  logic [12+F:0]       c2_n, c3_n;
  logic [13+2*F:0]     c2_p;
  logic [F-1:0]        c3_q;
  logic [12+F:0]       c3_pr;
  logic [12+F:0]       c4_rem;
  logic [F:0]          c4_tn;
  logic [F-1:0]        c4_t;
  logic [2*F-1:0]      c5_tt;
  logic [F+1:0]        c5_w;
  logic [3*F+1:0]      c6_m;
  logic [3*F+2:0]      c6_rd;

  always_comb begin
    c4_rem = c3_n - c3_pr;
    c4_tn  = {1'b0, c3_q} + (F+1)'(c4_rem >= (13+F)'(UP_SPAN));
    c6_rd  = {1'b0, c6_m} + ((3*F+3)'(1) << (2*F-1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v        <= '0;
      mask_valid <= 1'b0;
    end else if (adv) begin
      c_v        <= {c_v[4:0], r_v};
      mask_valid <= c_v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_lo[0] <= (r_up <= UP_LO);
      c_hi[0] <= (r_up >= UP_HI);
      c1_d    <= ((r_up > UP_LO) && (r_up < UP_HI)) ? 13'(r_up - UP_LO) : 13'd0;
      c_s[0]  <= r_s;
      for (int i = 1; i < 6; i++) begin
        c_lo[i] <= c_lo[i-1];
        c_hi[i] <= c_hi[i-1];
        c_s[i]  <= c_s[i-1];
      end
      c2_n  <= {c1_d, {F{1'b0}}};
      c2_p  <= (14+2*F)'({c1_d, {F{1'b0}}}) * (14+2*F)'(FLAT_M);
      c3_n  <= c2_n;
      c3_q  <= c2_p[FLAT_K+F-1:FLAT_K];
      c3_pr <= (13+F)'(c2_p[FLAT_K+F-1:FLAT_K]) * (13+F)'(UP_SPAN);
      c4_t  <= c4_tn[F-1:0];
      c5_tt <= (2*F)'(c4_t) * (2*F)'(c4_t);
      c5_w  <= (F+2)'(3 * (2**F)) - {1'b0, c4_t, 1'b0};
      c6_m  <= (3*F+2)'(c5_tt) * (3*F+2)'(c5_w);
      flatness  <= c_lo[5] ? '0 : (c_hi[5] ? ONE : c6_rd[3*F:2*F]);
      exposure  <= c_s[5][SDW-1:10];
      variation <= c_s[5][9:0];
    end
  end

  `TVMS_ASSERT_IMP(a_flat_range, mask_valid, flatness <= ONE)
  `TVMS_ASSERT_IMP(a_expo_range, mask_valid, exposure <= ONE)
  `TVMS_ASSERT_IMP(a_var_range, mask_valid, variation < VAR_MOD)
  `TVMS_ASSERT_IMP(a_slope_sat, g_v, (g_x <= SLOPE_SAT) && (g_y <= SLOPE_SAT))

endmodule

`default_nettype wire

[bench/tb_terrain_vertex_mask_shader_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terrain vertex mask shader testbench
// Streams heightfield vertices through the unit under several register
// settings with random idle and stall gaps, predicts each mask beat in a
// small scoreboard and compares flatness, exposure and variation in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_terrain_vertex_mask_shader_unit;
  import tvms_pkg::*;

  localparam int HB = HEIGHT_BITS_DEF;
  localparam int FB = MASK_FRAC_BITS_DEF;

  typedef struct {
    logic [15:0]          x;
    logic [15:0]          y;
    logic signed [HB-1:0] centre;
    logic signed [HB-1:0] base;
    logic signed [HB-1:0] left;
    logic signed [HB-1:0] right;
    logic signed [HB-1:0] down;
    logic signed [HB-1:0] upper;
  } vertex_t;

  typedef struct {
    logic [FB:0] flat;
    logic [FB:0] expo;
    logic [9:0]  vari;
  } masks_t;

  class mask_ledger;
    masks_t      pending_masks[$];
    int          errors;
    int          checked;
    longint unsigned width_q, depth_q, spacing_q, expo_depth_q;

    function new();
      width_q = FIELD_WIDTH_RST;
      depth_q = FIELD_DEPTH_RST;
      spacing_q = GRID_SPACING_RST;
      expo_depth_q = EXPOSURE_DEPTH_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [16:0] value);
      case (idx)
        CFG_FIELD_WIDTH: width_q = value;
        CFG_FIELD_DEPTH: depth_q = value;
        CFG_GRID_SPACING: spacing_q = value[15:0];
        CFG_EXPOSURE_DEPTH: expo_depth_q = value[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned slope_q16(longint unsigned idx, longint unsigned count,
                                        longint c, longint lo_h, longint hi_h,
                                        longint unsigned sp);
      bit has_lo, has_hi;
      longint unsigned n, mag, g;
      longint a, b, d;
      has_lo = idx > 0;
      has_hi = idx + 1 < count;
      n = has_lo + has_hi;
      if (n == 0) return 0;
      a = has_hi ? hi_h : c;
      b = has_lo ? lo_h : c;
      d = a - b;
      mag = (d < 0) ? -d : d;
      g = (mag << 16) / (n * sp);
      return (g > SLOPE_SAT) ? SLOPE_SAT : g;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function masks_t predict_masks(vertex_t v);
      masks_t m;
      longint unsigned sp, dep, gx, gy, tt, up2, up, t, flat, ediff, expo, one;
      longint ed;
      logic [31:0] hx, hy, hash;
      one = 64'd1 << FB;
      sp = spacing_q ? spacing_q : 1;
      dep = expo_depth_q ? expo_depth_q : 1;
      gx = slope_q16(v.x, width_q, v.centre, v.left, v.right, sp);
      gy = slope_q16(v.y, depth_q, v.centre, v.down, v.upper, sp);
      tt = (64'd1 << 32) + gx * gx + gy * gy;
      up2 = (64'd1 << 62) / tt;
      up = root_floor(up2);
      if (up <= UP_LO) flat = 0;
      else if (up >= UP_HI) flat = one;
      else begin
        t = ((up - UP_LO) << FB) / (UP_HI - UP_LO);
        flat = (t * t * (3 * one - 2 * t) + (64'd1 << (2 * FB - 1))) >> (2 * FB);
      end
      ed = longint'(v.centre) - longint'(v.base);
      ediff = (ed < 0) ? -ed : ed;
      expo = (ediff << FB) / dep;
      if (expo > one) expo = one;
      hx = 32'(v.x) * HASH_X;
      hy = 32'(v.y) * HASH_Y;
      hash = hx ^ hy;
      m.flat = flat[FB:0];
      m.expo = expo[FB:0];
      m.vari = 10'(hash % 1000);
      return m;
    endfunction

    function void note_vertex(vertex_t v);
      pending_masks.push_back(predict_masks(v));
    endfunction

    function void check_mask(masks_t got);
      masks_t want;
      if (pending_masks.size() == 0) begin
        $error("mask beat with nothing expected");
        errors++;
        return;
      end
      want = pending_masks.pop_front();
      checked++;
      if (got.flat !== want.flat) begin
        $error("flatness: expected %0d, got %0d", want.flat, got.flat);
        errors++;
      end
      if (got.expo !== want.expo) begin
        $error("exposure: expected %0d, got %0d", want.expo, got.expo);
        errors++;
      end
      if (got.vari !== want.vari) begin
        $error("variation: expected %0d, got %0d", want.vari, got.vari);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 cfg_we = 0;
  logic [1:0]           cfg_index = CFG_FIELD_WIDTH;
  logic [16:0]          cfg_data = 0;
  logic                 vertex_valid = 0;
  logic                 vertex_stall;
  logic [15:0]          vertex_x = 0;
  logic [15:0]          vertex_y = 0;
  logic signed [HB-1:0] center_height = 0;
  logic signed [HB-1:0] base_height = 0;
  logic signed [HB-1:0] left_height = 0;
  logic signed [HB-1:0] right_height = 0;
  logic signed [HB-1:0] down_height = 0;
  logic signed [HB-1:0] up_height = 0;
  logic                 mask_valid;
  logic                 mask_stall = 0;
  logic [FB:0]          flatness;
  logic [FB:0]          exposure;
  logic [9:0]           variation;

  mask_ledger ledger = new();
  bit         calm;
  int         stall_left;
  int         settings_run;

  terrain_vertex_mask_shader_unit uut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && mask_valid && !mask_stall) begin
      ledger.check_mask('{flat: flatness, expo: exposure, vari: variation});
      stall_left = calm ? 0 : $urandom_range(0, 14);
    end
    mask_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  task automatic send_vertex(vertex_t v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      vertex_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    vertex_valid <= 1;
    vertex_x <= v.x;
    vertex_y <= v.y;
    center_height <= v.centre;
    base_height <= v.base;
    left_height <= v.left;
    right_height <= v.right;
    down_height <= v.down;
    up_height <= v.upper;
    do @(posedge clk); while (vertex_stall);
    ledger.note_vertex(v);
  endtask

  task automatic drain();
    vertex_valid <= 0;
    while (ledger.pending_masks.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    ledger.set_reg(idx, value);
  endtask

  task automatic load_setting(logic [16:0] w, logic [16:0] d, logic [16:0] sp,
                              logic [16:0] dep);
    drain();
    write_reg(CFG_FIELD_WIDTH, w);
    write_reg(CFG_FIELD_DEPTH, d);
    write_reg(CFG_GRID_SPACING, sp);
    write_reg(CFG_EXPOSURE_DEPTH, dep);
    settings_run++;
  endtask

  function automatic logic [15:0] pick_index(longint unsigned count);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'(count - 1);
      2: return 16'(count);
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, (count > 1) ? count - 1 : 0));
    endcase
  endfunction

  function automatic logic signed [HB-1:0] near(logic signed [HB-1:0] c, int span);
    return HB'(int'(c) + $urandom_range(0, 2 * span) - span);
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    int sp, dep;
    sp = ledger.spacing_q ? int'(ledger.spacing_q) : 1;
    dep = ledger.expo_depth_q ? int'(ledger.expo_depth_q) : 1;
    v.x = pick_index(ledger.width_q);
    v.y = pick_index(ledger.depth_q);
    if ($urandom_range(0, 7) == 0) begin
      v.centre = HB'($urandom); v.base = HB'($urandom); v.left = HB'($urandom);
      v.right = HB'($urandom); v.down = HB'($urandom); v.upper = HB'($urandom);
    end else begin
      v.centre = $urandom_range(0, 1) ? HB'($urandom) : HB'($urandom_range(0, 65535));
      v.base = near(v.centre, 2 * dep);
      v.left = near(v.centre, 2 * sp);
      v.right = near(v.centre, 2 * sp);
      v.down = near(v.centre, 2 * sp);
      v.upper = near(v.centre, 2 * sp);
    end
    return v;
  endfunction

  initial begin
    vertex_t v;
    int      phase;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings, edges, extremes of heights
    calm = 0;
    v = '{x: 0, y: 0, centre: 0, base: 0, left: 0, right: 0, down: 0, upper: 0};
    send_vertex(v);
    v = '{x: 255, y: 255, centre: 24'sh7fffff, base: 24'sh800000, left: 24'sh800000,
          right: 24'sh7fffff, down: 24'sh800000, upper: 24'sh7fffff};
    send_vertex(v);
    v = '{x: 16'hffff, y: 16'hffff, centre: 24'sh800000, base: 24'sh7fffff,
          left: 24'sh7fffff, right: 0, down: 24'sh7fffff, upper: 0};
    send_vertex(v);
    v = '{x: 100, y: 100, centre: 1000, base: 1064, left: 0, right: 1600,
          down: 1000, upper: 1000};
    send_vertex(v);
    v = '{x: 300, y: 0, centre: 500, base: 372, left: 0, right: 9999,
          down: 0, upper: 1200};
    send_vertex(v);
    for (int i = 0; i < 8; i++) send_vertex(random_vertex());

    load_setting(1, 1, 1, 1);
    v = '{x: 0, y: 0, centre: 5, base: 3, left: 24'sh7fffff, right: 24'sh800000,
          down: 9, upper: -9};
    send_vertex(v);
    v.x = 7; v.y = 3;
    send_vertex(v);
    load_setting(0, 0, 0, 0);
    v = '{x: 4, y: 0, centre: 2, base: 0, left: 1, right: 9, down: 3, upper: 4};
    send_vertex(v);
    v.x = 0; v.y = 9;
    send_vertex(v);
    load_setting(65536, 65536, 65535, 65535);
    v = '{x: 16'hffff, y: 16'hfffe, centre: 24'sh7fffff, base: 24'sh800000,
          left: 24'sh800000, right: 24'sh7fffff, down: 24'sh7fffff, upper: 0};
    send_vertex(v);

    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: load_setting(2, 3, 16, 1);
        1: load_setting(65536, 1, 65535, 65535);
        2: load_setting(0, 0, 0, 0);
        default: load_setting(17'($urandom_range(1, 300)), 17'($urandom_range(1, 300)),
                              17'($urandom_range(1, 4000)), 17'($urandom_range(1, 4000)));
      endcase
      calm = (phase % 3 == 1);
      for (int i = 0; i < 148; i++) begin
        if (phase == 4 && i == 70) drain();
        send_vertex(random_vertex());
      end
    end

    drain();
    if (ledger.pending_masks.size() != 0) begin
      $error("%0d mask beats never arrived", ledger.pending_masks.size());
      ledger.errors++;
    end
    $display("Checked %0d mask beats across %0d register settings plus reset values",
             ledger.checked, settings_run);
    if (ledger.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+sv
sv/tvms_pkg.sv
sv/tvms_div_pipe.sv
sv/tvms_isqrt_pipe.sv
sv/terrain_vertex_mask_shader_unit.sv
bench/tb_terrain_vertex_mask_shader_unit.sv
